// ----- design/poly_voice_allocator_adsr_assert.svh -----
// Assertion macros used by the voice allocator checker.
`ifndef POLY_VOICE_ALLOCATOR_ADSR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ADSR_ASSERT_SVH

// Clocked assertion, quiet during reset.
`define PVA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PVA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/pva_pkg.sv -----
// Package: voice entry and config types, envelope step, command, status and register codes.
`timescale 1ns / 1ps
package pva_pkg;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_NOTEON = 3'd1;
  localparam logic [2:0] CMD_NOTEOFF = 3'd2;
  localparam logic [2:0] CMD_PEDAL  = 3'd3;
  localparam logic [2:0] CMD_ALLOFF = 3'd4;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_STOLEN  = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  localparam logic [15:0] FULL_SCALE = 16'd32768;
  localparam logic [6:0]  PEDAL_THRESHOLD = 7'd64;

  typedef struct packed {
    logic        on;
    logic        rel;
    logic        hold;
    logic        dec;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [15:0] level;
  } voice_t;

  typedef struct packed {
    logic [15:0] attack;
    logic [15:0] decay;
    logic [15:0] sustain;
    logic [15:0] release_step;
  } cfg_t;

  function automatic voice_t env_advance(voice_t v, cfg_t c);
    voice_t     r;
    logic [16:0] sum;
    logic [15:0] lvl;
    r   = v;
    sum = {1'b0, v.level} + {1'b0, c.attack};
    lvl = v.level;
    if (v.on && !v.hold) begin
      if (!v.rel) begin
        if (!v.dec) begin
          if (sum >= {1'b0, FULL_SCALE}) begin
            r.level = FULL_SCALE;
            r.dec   = 1'b1;
          end else begin
            r.level = sum[15:0];
          end
        end else if (lvl > c.sustain) begin
          lvl = (lvl > c.decay) ? lvl - c.decay : 16'd0;
          r.level = (lvl <= c.sustain) ? c.sustain : lvl;
        end
      end else if (lvl > c.release_step) begin
        r.level = lvl - c.release_step;
      end else begin
        r.level = 16'd0;
        r.on    = 1'b0;
        r.rel   = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ----- design/pva_cfg.sv -----
// APB register file for the envelope settings.
`timescale 1ns / 1ps
module pva_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pva_pkg::cfg_t cfg
);
  import pva_pkg::*;

  logic [1:0] sel;
  assign sel    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack       <= 16'd68;
      cfg.decay        <= 16'd0;
      cfg.sustain      <= 16'd32768;
      cfg.release_step <= 16'd68;
    end else if (psel && penable && pwrite && pready) begin
      unique case (sel)
        REG_ATTACK:  cfg.attack       <= pwdata[15:0];
        REG_DECAY:   cfg.decay        <= pwdata[15:0];
        REG_SUSTAIN: cfg.sustain      <= pwdata[15:0];
        REG_RELEASE: cfg.release_step <= pwdata[15:0];
        default:     cfg.attack       <= cfg.attack;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_ATTACK:  prdata = {16'd0, cfg.attack};
      REG_DECAY:   prdata = {16'd0, cfg.decay};
      REG_SUSTAIN: prdata = {16'd0, cfg.sustain};
      REG_RELEASE: prdata = {16'd0, cfg.release_step};
      default:     prdata = 32'd0;
    endcase
  end
endmodule

// ----- design/pva_vmem.sv -----
// Voice table memory with per-entry valid bits and a registered read.
`timescale 1ns / 1ps
module pva_vmem #(
  parameter int VOICES = 8,
  parameter int IW = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic [IW-1:0]   rd_addr,
  output pva_pkg::voice_t rd_data,
  input  logic            we,
  input  logic [IW-1:0]   wr_addr,
  input  pva_pkg::voice_t wr_data
);
  import pva_pkg::*;

  voice_t              mem [VOICES];
  voice_t              mem_q;
  logic [VOICES-1:0]   valid;
  logic                valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  // Entries never written since reset or all-off read as an idle voice.
  assign rd_data = valid_q ? mem_q : '0;
endmodule

// ----- design/poly_voice_allocator_adsr.sv -----
// Top level: polyphonic voice allocator with linear ADSR envelopes.
// Tick: VOICES results, one per voice; each voice passes S_RD, S_EV (write-back) and
// S_OUT, which waits while the output stalls. Note on / note off / pedal up: one read
// per voice via the single memory read port, then S_FIN and one result.
// Pedal down, all notes off: S_FIN and one result. One request in work at a time.
// Reset (synchronous, rst high): clears valid bits and pedal at once, no sweep.
`timescale 1ns / 1ps
module poly_voice_allocator_adsr #(
  parameter int VOICES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata: cmd[2:0], note[9:3], velocity[16:10], pedal_value[23:17]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // m_axis_tdata: voice_index[2:0], voice_note[9:3], voice_velocity[16:10],
  //   envelope[32:17], voice_active[33], voice_releasing[34], voice_held[35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // m_axis_tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pva_pkg::*;

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t      state, state_next;
  cfg_t        cfg;

  // Request held for the duration of the scan.
  logic [2:0]  cmd;
  logic [6:0]  note;
  logic [6:0]  vel;
  logic        pedal_down;

  // Scan bookkeeping.
  logic [IW-1:0] idx;
  logic          found;
  logic [IW-1:0] pick;
  logic [IW-1:0] steal;
  logic [22:0]   best;
  voice_t        pick_ent;

  // Memory access.
  voice_t        rd_data;
  logic          we;
  logic [IW-1:0] wr_addr;
  voice_t        wr_data;
  logic          clr;

  // Result register.
  logic [IW-1:0] o_idx;
  voice_t        o_ent;
  logic [1:0]    o_status;
  logic          o_last;

  logic          s_acc;
  logic          is_off;
  voice_t        adv;
  voice_t        noff_ent;
  logic [6:0]    weight;
  logic [22:0]   loud;
  logic [5:0]    idx_ext;

  pva_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pva_vmem #(.VOICES(VOICES), .IW(IW)) u_vmem (
    .clk, .rst, .clr,
    .rd_addr (idx),
    .rd_data,
    .we, .wr_addr, .wr_data
  );

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign clr           = s_acc && (s_axis_tdata[2:0] == CMD_ALLOFF);

  // A note-on with zero velocity behaves as a note-off.
  assign is_off = (cmd == CMD_NOTEOFF) || (cmd == CMD_NOTEON && vel == 7'd0);

  assign adv    = env_advance(rd_data, cfg);
  assign weight = (rd_data.vel == 7'd0) ? 7'd1 : rd_data.vel;
  assign loud   = 23'(rd_data.level) * 23'(weight);

  always_comb begin
    noff_ent = pick_ent;
    if (pedal_down) begin
      noff_ent.hold = 1'b1;
    end else begin
      noff_ent.rel = 1'b1;
    end
  end

  // Next state and memory write.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    wr_addr    = idx;
    wr_data    = adv;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          priority case (s_axis_tdata[2:0])
            CMD_TICK, CMD_NOTEON, CMD_NOTEOFF: state_next = S_RD;
            CMD_PEDAL: state_next = (s_axis_tdata[23:17] >= PEDAL_THRESHOLD) ? S_FIN : S_RD;
            CMD_ALLOFF: state_next = S_FIN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD: state_next = S_EV;
      S_EV: begin
        if (cmd == CMD_TICK) begin
          we         = 1'b1;
          state_next = S_OUT;
        end else begin
          if (cmd == CMD_PEDAL && rd_data.hold) begin
            we          = 1'b1;
            wr_data     = rd_data;
            wr_data.hold = 1'b0;
            wr_data.rel = 1'b1;
          end
          state_next = (idx == LAST_IDX) ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (cmd == CMD_NOTEON && !is_off) begin
          we      = 1'b1;
          wr_addr = found ? pick : steal;
          wr_data = '{on: 1'b1, rel: 1'b0, hold: 1'b0, dec: 1'b0,
                      key: note, vel: vel, level: 16'd0};
        end else if (is_off && found) begin
          we      = 1'b1;
          wr_addr = pick;
          wr_data = noff_ent;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_next = o_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pedal_down <= 1'b0;
      idx        <= '0;
      found      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && s_acc) begin
        idx   <= '0;
        found <= 1'b0;
        if (s_axis_tdata[2:0] == CMD_PEDAL) begin
          pedal_down <= (s_axis_tdata[23:17] >= PEDAL_THRESHOLD);
        end else if (s_axis_tdata[2:0] == CMD_ALLOFF) begin
          pedal_down <= 1'b0;
        end
      end else if (state == S_EV) begin
        if (cmd != CMD_TICK && idx != LAST_IDX) begin
          idx <= idx + 1'b1;
        end
        // First free voice for note-on, first matching voice for note-off.
        if (!found && cmd == CMD_NOTEON && !is_off && !rd_data.on && !rd_data.rel) begin
          found <= 1'b1;
        end
        if (!found && is_off && rd_data.on && !rd_data.rel && rd_data.key == note) begin
          found <= 1'b1;
        end
      end else if (state == S_OUT && m_axis_tready && !o_last) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Request capture and scan datapath.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_acc) begin
      cmd  <= s_axis_tdata[2:0];
      note <= s_axis_tdata[9:3];
      vel  <= s_axis_tdata[16:10];
    end
    if (state == S_EV && !found) begin
      if (cmd == CMD_NOTEON && !is_off) begin
        if (!rd_data.on && !rd_data.rel) begin
          pick <= idx;
        end
        // Quietest voice, ties to the lowest index.
        if (idx == '0 || loud < best) begin
          best  <= loud;
          steal <= idx;
        end
      end
      if (is_off && rd_data.on && !rd_data.rel && rd_data.key == note) begin
        pick     <= idx;
        pick_ent <= rd_data;
      end
    end
  end

  // Load the result register.
  always_ff @(posedge clk) begin
    if (state == S_EV && cmd == CMD_TICK) begin
      o_idx    <= idx;
      o_ent    <= adv;
      o_status <= ST_DONE;
      o_last   <= (idx == LAST_IDX);
    end else if (state == S_FIN) begin
      o_last <= 1'b1;
      if (cmd == CMD_NOTEON && !is_off) begin
        o_idx    <= found ? pick : steal;
        o_ent    <= wr_data;
        o_status <= found ? ST_FREE : ST_STOLEN;
      end else if (is_off) begin
        o_idx    <= found ? pick : '0;
        o_ent    <= found ? noff_ent : '0;
        o_status <= found ? ST_DONE : ST_NOMATCH;
      end else begin
        o_idx    <= '0;
        o_ent    <= '0;
        o_status <= ST_DONE;
      end
    end
  end

  assign idx_ext       = 6'(o_idx);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {4'd0, o_ent.hold, o_ent.rel, o_ent.on, o_ent.level,
                          o_ent.vel, o_ent.key, idx_ext[2:0]};
  assign m_axis_tuser  = o_status;
  assign m_axis_tlast  = o_last;
endmodule

// ----- design/pva_checker.sv -----
// Port-level checker for the voice allocator and its bind.
`timescale 1ns / 1ps
`include "poly_voice_allocator_adsr_assert.svh"
module pva_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import pva_pkg::*;

  `PVA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `PVA_ASSERT(a_in_idle, s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid, "request taken while busy")
  `PVA_ASSERT(a_last_free, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready, "not ready after final result")
  `PVA_ASSERT(a_single, m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tlast, "single result not marked last")
  `PVA_ASSERT_ALWAYS(a_rst, rst |=> !m_axis_tvalid, "result after reset")
endmodule

bind poly_voice_allocator_adsr pva_checker u_pva_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tuser, .m_axis_tlast
);
